/* rtl/gda_pkg.sv */
// Shared types, constants and calendar functions for the Gregorian date adder.
`timescale 1ns / 1ps

package gda_pkg;

  localparam int unsigned YEAR_W  = 15;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned CNT_W   = 15;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned PC_W    = 5;
  localparam int unsigned Q_W     = 9;

  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 15'd32767;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_28    = 5'd28;
  localparam logic [DAY_W-1:0]   DAY_29    = 5'd29;

  // floor(y / 100) = (y * 5243) >> 19, exact for 15-bit y
  localparam logic [27:0] DIV100_MUL   = 28'd5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam logic [YEAR_W-1:0] CENTURY = 15'd100;

  localparam logic [FUNC_W-1:0] FN_DAYS   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_MONTHS = 2'd1;
  localparam logic [FUNC_W-1:0] FN_YEARS  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_LQ,
    OP_LF,
    OP_CHK,
    OP_DSTEP,
    OP_MSTEP,
    OP_YADD,
    OP_YFIX,
    OP_FIN
  } op_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NOSTART,
    C_ERR,
    C_F0,
    C_F1,
    C_F2,
    C_LEFT0,
    C_DLOOP,
    C_MLOOP,
    C_HOLD
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic start;
    logic err;
    logic f0;
    logic f1;
    logic f2;
    logic left0;
    logic dloop;
    logic mloop;
    logic hold;
  } flags_t;

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m, input logic lp);
    logic [DAY_W-1:0] len;
    len = '0;
    if (m >= MONTH_JAN && m <= MONTH_DEC) begin
      len = MONTH_LEN[m - MONTH_JAN];
      if (m == MONTH_FEB && lp) begin
        len = DAY_29;
      end
    end
    return len;
  endfunction

endpackage

/* rtl/gda_if.sv */
// Valid/ready channel interfaces for date requests and results.
`timescale 1ns / 1ps

interface gda_req_if;
  logic                          valid;
  logic                          ready;
  logic [gda_pkg::FUNC_W-1:0]    func;
  logic [gda_pkg::YEAR_W-1:0]    in_year;
  logic [gda_pkg::MONTH_W-1:0]   in_month;
  logic [gda_pkg::DAY_W-1:0]     in_day;
  logic [gda_pkg::CNT_W-1:0]     count;

  modport source (output valid, func, in_year, in_month, in_day, count, input ready);
  modport sink (input valid, func, in_year, in_month, in_day, count, output ready);
endinterface

interface gda_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [gda_pkg::YEAR_W-1:0]    out_year;
  logic [gda_pkg::MONTH_W-1:0]   out_month;
  logic [gda_pkg::DAY_W-1:0]     out_day;
  logic [gda_pkg::STAT_W-1:0]    status;

  modport source (output valid, out_year, out_month, out_day, status, input ready);
  modport sink (input valid, out_year, out_month, out_day, status, output ready);
endinterface

/* rtl/gda_urom.sv */
// Microprogram ROM: one control word per step.
`timescale 1ns / 1ps

module gda_urom (
  input  logic [gda_pkg::PC_W-1:0] pc,
  output gda_pkg::ctl_t            ctl
);

  localparam logic [gda_pkg::PC_W-1:0] S_IDLE  = 5'd0;
  localparam logic [gda_pkg::PC_W-1:0] S_DAYS  = 5'd9;
  localparam logic [gda_pkg::PC_W-1:0] S_DLOOP = 5'd10;
  localparam logic [gda_pkg::PC_W-1:0] S_MON   = 5'd16;
  localparam logic [gda_pkg::PC_W-1:0] S_MLOOP = 5'd17;
  localparam logic [gda_pkg::PC_W-1:0] S_YEAR  = 5'd23;
  localparam logic [gda_pkg::PC_W-1:0] S_FIN   = 5'd28;

  always_comb begin
    case (pc)
      5'd0:  ctl = '{op: gda_pkg::OP_LOAD,  cond: gda_pkg::C_NOSTART, target: S_IDLE};
      5'd1:  ctl = '{op: gda_pkg::OP_LQ,    cond: gda_pkg::C_NONE,    target: S_IDLE};
      5'd2:  ctl = '{op: gda_pkg::OP_LF,    cond: gda_pkg::C_NONE,    target: S_IDLE};
      5'd3:  ctl = '{op: gda_pkg::OP_CHK,   cond: gda_pkg::C_NONE,    target: S_IDLE};
      5'd4:  ctl = '{op: gda_pkg::OP_NOP,   cond: gda_pkg::C_ERR,     target: S_FIN};
      5'd5:  ctl = '{op: gda_pkg::OP_NOP,   cond: gda_pkg::C_F0,      target: S_DAYS};
      5'd6:  ctl = '{op: gda_pkg::OP_NOP,   cond: gda_pkg::C_F1,      target: S_MON};
      5'd7:  ctl = '{op: gda_pkg::OP_NOP,   cond: gda_pkg::C_F2,      target: S_YEAR};
      5'd8:  ctl = '{op: gda_pkg::OP_NOP,   cond: gda_pkg::C_ALWAYS,  target: S_FIN};
      // add days, one month per step
      5'd9:  ctl = '{op: gda_pkg::OP_NOP,   cond: gda_pkg::C_LEFT0,   target: S_FIN};
      5'd10: ctl = '{op: gda_pkg::OP_DSTEP, cond: gda_pkg::C_DLOOP,   target: S_DLOOP};
      5'd11: ctl = '{op: gda_pkg::OP_NOP,   cond: gda_pkg::C_ERR,     target: S_FIN};
      5'd12: ctl = '{op: gda_pkg::OP_NOP,   cond: gda_pkg::C_LEFT0,   target: S_FIN};
      5'd13: ctl = '{op: gda_pkg::OP_LQ,    cond: gda_pkg::C_NONE,    target: S_IDLE};
      5'd14: ctl = '{op: gda_pkg::OP_LF,    cond: gda_pkg::C_NONE,    target: S_IDLE};
      5'd15: ctl = '{op: gda_pkg::OP_NOP,   cond: gda_pkg::C_ALWAYS,  target: S_DLOOP};
      // add months, one month per step
      5'd16: ctl = '{op: gda_pkg::OP_NOP,   cond: gda_pkg::C_LEFT0,   target: S_FIN};
      5'd17: ctl = '{op: gda_pkg::OP_MSTEP, cond: gda_pkg::C_MLOOP,   target: S_MLOOP};
      5'd18: ctl = '{op: gda_pkg::OP_NOP,   cond: gda_pkg::C_ERR,     target: S_FIN};
      5'd19: ctl = '{op: gda_pkg::OP_NOP,   cond: gda_pkg::C_LEFT0,   target: S_FIN};
      5'd20: ctl = '{op: gda_pkg::OP_LQ,    cond: gda_pkg::C_NONE,    target: S_IDLE};
      5'd21: ctl = '{op: gda_pkg::OP_LF,    cond: gda_pkg::C_NONE,    target: S_IDLE};
      5'd22: ctl = '{op: gda_pkg::OP_NOP,   cond: gda_pkg::C_ALWAYS,  target: S_MLOOP};
      // add years
      5'd23: ctl = '{op: gda_pkg::OP_YADD,  cond: gda_pkg::C_NONE,    target: S_IDLE};
      5'd24: ctl = '{op: gda_pkg::OP_NOP,   cond: gda_pkg::C_ERR,     target: S_FIN};
      5'd25: ctl = '{op: gda_pkg::OP_LQ,    cond: gda_pkg::C_NONE,    target: S_IDLE};
      5'd26: ctl = '{op: gda_pkg::OP_LF,    cond: gda_pkg::C_NONE,    target: S_IDLE};
      5'd27: ctl = '{op: gda_pkg::OP_YFIX,  cond: gda_pkg::C_ALWAYS,  target: S_FIN};
      // result
      5'd28: ctl = '{op: gda_pkg::OP_FIN,   cond: gda_pkg::C_HOLD,    target: S_FIN};
      5'd29: ctl = '{op: gda_pkg::OP_NOP,   cond: gda_pkg::C_ALWAYS,  target: S_IDLE};
      default: ctl = '{op: gda_pkg::OP_NOP, cond: gda_pkg::C_ALWAYS,  target: S_IDLE};
    endcase
  end

endmodule

/* rtl/gda_seq.sv */
// Microsequencer: step counter, ROM lookup and conditional jumps.
`timescale 1ns / 1ps

module gda_seq (
  input  logic             clk,
  input  logic             rst,
  input  gda_pkg::flags_t  flags,
  output gda_pkg::ctl_t    ctl
);

  logic [gda_pkg::PC_W-1:0] pc;
  logic [gda_pkg::PC_W-1:0] pc_next;
  logic                     take;

  gda_urom u_urom (
    .pc  (pc),
    .ctl (ctl)
  );

  always_comb begin
    case (ctl.cond)
      gda_pkg::C_NONE:    take = 1'b0;
      gda_pkg::C_ALWAYS:  take = 1'b1;
      gda_pkg::C_NOSTART: take = !flags.start;
      gda_pkg::C_ERR:     take = flags.err;
      gda_pkg::C_F0:      take = flags.f0;
      gda_pkg::C_F1:      take = flags.f1;
      gda_pkg::C_F2:      take = flags.f2;
      gda_pkg::C_LEFT0:   take = flags.left0;
      gda_pkg::C_DLOOP:   take = flags.dloop;
      gda_pkg::C_MLOOP:   take = flags.mloop;
      gda_pkg::C_HOLD:    take = flags.hold;
      default:            take = 1'b1;
    endcase
    pc_next = take ? ctl.target : pc + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* rtl/gda_dp.sv */
// Date datapath: date registers, leap-year unit, step logic and result register.
`timescale 1ns / 1ps

module gda_dp (
  input  logic            clk,
  input  logic            rst,
  input  gda_pkg::ctl_t   ctl,
  output gda_pkg::flags_t flags,
  gda_req_if.sink         req,
  gda_rsp_if.source       rsp
);

  logic [gda_pkg::YEAR_W-1:0]  y, y0;
  logic [gda_pkg::MONTH_W-1:0] m, m0;
  logic [gda_pkg::DAY_W-1:0]   d, d0;
  logic [gda_pkg::CNT_W-1:0]   left;
  logic [gda_pkg::FUNC_W-1:0]  fn;
  logic [gda_pkg::STAT_W-1:0]  st;
  logic [gda_pkg::Q_W-1:0]     q;
  logic                        leap;

  logic [27:0]                 prod;
  logic [gda_pkg::YEAR_W-1:0]  cent;
  logic                        leap_next;
  logic [gda_pkg::DAY_W-1:0]   dim_cur;
  logic [gda_pkg::DAY_W-1:0]   dim_nxt;
  logic [gda_pkg::DAY_W:0]     to_next;
  logic                        jump;
  logic                        invalid;
  logic [gda_pkg::YEAR_W:0]    ysum;
  logic                        hold;

  always_comb begin
    prod      = {13'b0, y} * gda_pkg::DIV100_MUL;
    cent      = {6'b0, q} * gda_pkg::CENTURY;
    leap_next = (y[1:0] == 2'b00) && ((y != cent) || (q[1:0] == 2'b00));
    dim_cur   = gda_pkg::days_in(m, leap);
    dim_nxt   = gda_pkg::days_in(m + 4'd1, leap);
    to_next   = {1'b0, dim_cur} - {1'b0, d} + 6'd1;
    jump      = {9'b0, to_next} <= left;
    invalid   = (dim_cur == '0) || (d == '0) || (d > dim_cur);
    ysum      = {1'b0, y} + {1'b0, left};
    hold      = rsp.valid && !rsp.ready;
  end

  assign req.ready = (ctl.op == gda_pkg::OP_LOAD) && !rst;

  always_comb begin
    flags.start = req.valid;
    flags.err   = (st != gda_pkg::ST_OK);
    flags.f0    = (fn == gda_pkg::FN_DAYS);
    flags.f1    = (fn == gda_pkg::FN_MONTHS);
    flags.f2    = (fn == gda_pkg::FN_YEARS);
    flags.left0 = (left == '0);
    flags.dloop = jump && (m != gda_pkg::MONTH_DEC);
    flags.mloop = (m != gda_pkg::MONTH_DEC) && (left != 15'd1);
    flags.hold  = hold;
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      gda_pkg::OP_LOAD: begin
        if (req.valid) begin
          y    <= req.in_year;
          m    <= req.in_month;
          d    <= req.in_day;
          y0   <= req.in_year;
          m0   <= req.in_month;
          d0   <= req.in_day;
          left <= req.count;
          fn   <= req.func;
          st   <= gda_pkg::ST_OK;
        end
      end
      gda_pkg::OP_LQ: begin
        q <= prod[gda_pkg::DIV100_SHIFT +: gda_pkg::Q_W];
      end
      gda_pkg::OP_LF: begin
        leap <= leap_next;
      end
      gda_pkg::OP_CHK: begin
        if (invalid) begin
          st <= gda_pkg::ST_INVALID;
        end
      end
      gda_pkg::OP_DSTEP: begin
        if (jump) begin
          left <= left - {9'b0, to_next};
          d    <= gda_pkg::DAY_FIRST;
          if (m == gda_pkg::MONTH_DEC) begin
            if (y == gda_pkg::YEAR_MAX) begin
              st <= gda_pkg::ST_OVERFLOW;
            end else begin
              y <= y + 15'd1;
              m <= gda_pkg::MONTH_JAN;
            end
          end else begin
            m <= m + 4'd1;
          end
        end else begin
          d    <= d + left[gda_pkg::DAY_W-1:0];
          left <= '0;
        end
      end
      gda_pkg::OP_MSTEP: begin
        left <= left - 15'd1;
        if (m == gda_pkg::MONTH_DEC) begin
          if (y == gda_pkg::YEAR_MAX) begin
            st <= gda_pkg::ST_OVERFLOW;
          end else begin
            y <= y + 15'd1;
            m <= gda_pkg::MONTH_JAN;
          end
        end else begin
          m <= m + 4'd1;
          if (d > dim_nxt) begin
            d <= dim_nxt;
          end
        end
      end
      gda_pkg::OP_YADD: begin
        if (ysum[gda_pkg::YEAR_W]) begin
          st <= gda_pkg::ST_OVERFLOW;
        end else begin
          y <= ysum[gda_pkg::YEAR_W-1:0];
        end
      end
      gda_pkg::OP_YFIX: begin
        if (m == gda_pkg::MONTH_FEB && d == gda_pkg::DAY_29 && !leap) begin
          d <= gda_pkg::DAY_28;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.op == gda_pkg::OP_FIN && !hold) begin
      rsp.status <= st;
      if (st != gda_pkg::ST_OK) begin
        rsp.out_year  <= y0;
        rsp.out_month <= m0;
        rsp.out_day   <= d0;
      end else begin
        rsp.out_year  <= y;
        rsp.out_month <= m;
        rsp.out_day   <= d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (ctl.op == gda_pkg::OP_FIN && !hold) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

endmodule

/* rtl/gregorian_date_adder.sv */
// Top level of the Gregorian date adder: microsequencer plus date datapath.
//
//   Channel  Role    Word
//   req      sink    func, in_year, in_month, in_day, count
//   rsp      source  out_year, out_month, out_day, status
//
// One word at a time. Setup runs load, leap unit, date check and dispatch
// (an invalid date skips the dispatch), then the result step. Add days and add
// months take one step per month crossed and rerun the leap unit on each year
// crossed. Add years adds the count, reruns the leap unit and fixes 29 February.
// rst is synchronous; the result register holds a word under stall, and
// req is taken again once the result is latched.
`timescale 1ns / 1ps

module gregorian_date_adder (
  input  logic       clk,
  input  logic       rst,
  gda_req_if.sink    req,
  gda_rsp_if.source  rsp
);

  gda_pkg::ctl_t   ctl;
  gda_pkg::flags_t flags;

  gda_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  gda_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .flags (flags),
    .req   (req),
    .rsp   (rsp)
  );

endmodule

/* verif/gregorian_date_adder_tb.sv */
// Self-checking testbench for gregorian_date_adder: directed table, then random date words.
`timescale 1ns / 1ps

module gregorian_date_adder_tb;
  import gda_pkg::*;

  localparam logic [FUNC_W-1:0] FN_NONE = 2'd3;
  localparam int NUM_DIRECTED = 25;
  localparam int NUM_RANDOM = 75;
  localparam int HOLD_CYCLES = 4000;
  localparam int DRAIN_CYCLES = 30;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [YEAR_W-1:0]  in_year;
    logic [MONTH_W-1:0] in_month;
    logic [DAY_W-1:0]   in_day;
    logic [CNT_W-1:0]   count;
  } date_req_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [STAT_W-1:0]  status;
  } date_rsp_t;

  typedef struct packed {
    date_req_t word;
    logic      typed;
    date_rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic no_idle;
  logic hold_rsp;
  int   mismatches;
  int   n_ok;
  int   n_invalid;
  int   n_overflow;
  int   n_func [4];

  date_rsp_t expected_dates [$];
  dir_row_t  directed_tbl [NUM_DIRECTED];

  gda_req_if req ();
  gda_rsp_if rsp ();

  gregorian_date_adder u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic bit is_leap(int y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int month_days(int m, int y);
    if (m < 1 || m > 12) begin
      return 0;
    end
    if (m == 2) begin
      return is_leap(y) ? 29 : 28;
    end
    return int'(MONTH_LEN[m - 1]);
  endfunction

  function automatic date_rsp_t predict_date(date_req_t w);
    int y;
    int m;
    int d;
    int left;
    int span;
    logic [STAT_W-1:0] st;
    date_rsp_t r;
    y = int'(w.in_year);
    m = int'(w.in_month);
    d = int'(w.in_day);
    st = ST_OK;
    if (m < 1 || m > 12 || d == 0 || d > month_days(m, y)) begin
      st = ST_INVALID;
    end else if (w.func == FN_DAYS) begin
      left = int'(w.count);
      while (left > 0 && st == ST_OK) begin
        span = month_days(m, y) - d + 1;
        if (left >= span) begin
          left -= span;
          d = 1;
          if (m == 12) begin
            if (y >= int'(YEAR_MAX)) begin
              st = ST_OVERFLOW;
            end else begin
              y++;
              m = 1;
            end
          end else begin
            m++;
          end
        end else begin
          d += left;
          left = 0;
        end
      end
    end else if (w.func == FN_MONTHS) begin
      if (y + (m - 1 + int'(w.count)) / 12 > int'(YEAR_MAX)) begin
        st = ST_OVERFLOW;
      end else begin
        for (int i = 0; i < int'(w.count); i++) begin
          if (m == 12) begin
            m = 1;
            y++;
          end else begin
            m++;
          end
          if (d > month_days(m, y)) begin
            d = month_days(m, y);
          end
        end
      end
    end else if (w.func == FN_YEARS) begin
      if (y + int'(w.count) > int'(YEAR_MAX)) begin
        st = ST_OVERFLOW;
      end else begin
        y += int'(w.count);
        if (m == 2 && d == 29 && !is_leap(y)) begin
          d = 28;
        end
      end
    end
    if (st != ST_OK) begin
      y = int'(w.in_year);
      m = int'(w.in_month);
      d = int'(w.in_day);
    end
    r.year = YEAR_W'(y);
    r.month = MONTH_W'(m);
    r.day = DAY_W'(d);
    r.status = st;
    return r;
  endfunction

  task automatic send_date(input date_req_t w, input date_rsp_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk);
      req.valid = 1'b0;
    end
    @(negedge clk);
    req.valid = 1'b1;
    req.func = w.func;
    req.in_year = w.in_year;
    req.in_month = w.in_month;
    req.in_day = w.in_day;
    req.count = w.count;
    @(posedge clk);
    while (!req.ready) begin
      @(posedge clk);
    end
    expected_dates.push_back(want);
    n_func[w.func]++;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    gap = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
      end
      if (rst || gap > 0) begin
        rsp.ready = 1'b0;
        if (!rst) begin
          gap--;
        end
      end else begin
        rsp.ready = 1'b1;
      end
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        gap = no_idle ? 0 : $urandom_range(0, 19);
      end
    end
  end

  always @(posedge clk) begin
    date_rsp_t got;
    date_rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.out_year, rsp.out_month, rsp.out_day, rsp.status};
      if (expected_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("unexpected result word: %0d-%0d-%0d status %0d",
                   got.year, got.month, got.day, got.status);
        end
      end else begin
        want = expected_dates.pop_front();
        case (want.status)
          ST_OK: n_ok++;
          ST_INVALID: n_invalid++;
          default: n_overflow++;
        endcase
        if (got.year !== want.year || got.month !== want.month ||
            got.day !== want.day || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("date mismatch: expected %0d-%0d-%0d status %0d, got %0d-%0d-%0d status %0d",
                     want.year, want.month, want.day, want.status,
                     got.year, got.month, got.day, got.status);
          end
        end
      end
    end
  end

  initial begin
    date_req_t w;
    date_rsp_t want;
    int kind;
    int len;
    int big_left;
    rst = 1'b1;
    no_idle = 1'b0;
    hold_rsp = 1'b0;
    mismatches = 0;
    n_ok = 0;
    n_invalid = 0;
    n_overflow = 0;
    n_func = '{default: 0};
    big_left = 3;
    req.valid = 1'b0;
    req.func = FN_DAYS;
    req.in_year = '0;
    req.in_month = '0;
    req.in_day = '0;
    req.count = '0;

    directed_tbl = '{
      {FN_DAYS,   15'd2000,  4'd1,  5'd1,  15'd0,     1'b1, 15'd2000,  4'd1,  5'd1,  ST_OK},
      {FN_DAYS,   15'd5,     4'd0,  5'd1,  15'd3,     1'b1, 15'd5,     4'd0,  5'd1,  ST_INVALID},
      {FN_YEARS,  15'd32767, 4'd15, 5'd31, 15'd32767, 1'b1, 15'd32767, 4'd15, 5'd31, ST_INVALID},
      {FN_MONTHS, 15'd2001,  4'd3,  5'd0,  15'd7,     1'b1, 15'd2001,  4'd3,  5'd0,  ST_INVALID},
      {FN_DAYS,   15'd1900,  4'd2,  5'd29, 15'd1,     1'b1, 15'd1900,  4'd2,  5'd29, ST_INVALID},
      {FN_DAYS,   15'd2000,  4'd2,  5'd29, 15'd1,     1'b1, 15'd2000,  4'd3,  5'd1,  ST_OK},
      {FN_YEARS,  15'd0,     4'd2,  5'd29, 15'd1,     1'b1, 15'd1,     4'd2,  5'd28, ST_OK},
      {FN_DAYS,   15'd32767, 4'd12, 5'd31, 15'd1,     1'b1, 15'd32767, 4'd12, 5'd31, ST_OVERFLOW},
      {FN_DAYS,   15'd0,     4'd1,  5'd1,  15'd32767, 1'b0, 26'd0},
      {FN_MONTHS, 15'd32767, 4'd12, 5'd1,  15'd1,     1'b1, 15'd32767, 4'd12, 5'd1,  ST_OVERFLOW},
      {FN_MONTHS, 15'd0,     4'd1,  5'd31, 15'd32767, 1'b0, 26'd0},
      {FN_MONTHS, 15'd2023,  4'd1,  5'd31, 15'd2,     1'b1, 15'd2023,  4'd3,  5'd28, ST_OK},
      {FN_YEARS,  15'd32767, 4'd1,  5'd1,  15'd1,     1'b1, 15'd32767, 4'd1,  5'd1,  ST_OVERFLOW},
      {FN_YEARS,  15'd0,     4'd1,  5'd1,  15'd32767, 1'b1, 15'd32767, 4'd1,  5'd1,  ST_OK},
      {FN_YEARS,  15'd2000,  4'd2,  5'd29, 15'd4,     1'b1, 15'd2004,  4'd2,  5'd29, ST_OK},
      {FN_YEARS,  15'd2000,  4'd2,  5'd29, 15'd100,   1'b1, 15'd2100,  4'd2,  5'd28, ST_OK},
      {FN_NONE,   15'd2024,  4'd6,  5'd15, 15'd5,     1'b1, 15'd2024,  4'd6,  5'd15, ST_OK},
      {FN_NONE,   15'd2024,  4'd4,  5'd31, 15'd5,     1'b1, 15'd2024,  4'd4,  5'd31, ST_INVALID},
      {FN_DAYS,   15'd1999,  4'd12, 5'd31, 15'd1,     1'b1, 15'd2000,  4'd1,  5'd1,  ST_OK},
      {FN_MONTHS, 15'd2024,  4'd5,  5'd17, 15'd0,     1'b1, 15'd2024,  4'd5,  5'd17, ST_OK},
      {FN_MONTHS, 15'd2023,  4'd12, 5'd31, 15'd2,     1'b1, 15'd2024,  4'd2,  5'd29, ST_OK},
      {FN_MONTHS, 15'd32766, 4'd12, 5'd15, 15'd12,    1'b0, 26'd0},
      {FN_DAYS,   15'd32700, 4'd1,  5'd1,  15'd32767, 1'b0, 26'd0},
      {FN_YEARS,  15'd16383, 4'd10, 5'd16, 15'd16384, 1'b1, 15'd32767, 4'd10, 5'd16, ST_OK},
      {FN_DAYS,   15'd1,     4'd2,  5'd28, 15'd1,     1'b1, 15'd1,     4'd3,  5'd1,  ST_OK}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      want = directed_tbl[i].typed ? directed_tbl[i].want : predict_date(directed_tbl[i].word);
      send_date(directed_tbl[i].word, want);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 20) begin
        hold_rsp = 1'b1;
      end
      if (i == 50) begin
        @(negedge clk);
        req.valid = 1'b0;
        while (expected_dates.size() != 0) begin
          @(posedge clk);
        end
      end
      no_idle = (i >= 55 && i < 70);
      kind = $urandom_range(0, 19);
      if (kind < 3) begin
        // raw fields, including out-of-range months and days
        w.func = FUNC_W'($urandom_range(0, 3));
        w.in_year = YEAR_W'($urandom_range(0, 32767));
        w.in_month = MONTH_W'($urandom_range(0, 15));
        w.in_day = DAY_W'($urandom_range(0, 31));
        w.count = CNT_W'($urandom_range(0, 32767));
        if (w.func == FN_MONTHS) begin
          w.count = {6'd0, w.count[8:0]};
        end
      end else begin
        w.func = ($urandom_range(0, 15) == 0) ? FN_NONE : FUNC_W'($urandom_range(0, 2));
        case ($urandom_range(0, 3))
          0: w.in_year = YEAR_W'($urandom_range(0, 32767));
          1: w.in_year = YEAR_W'($urandom_range(32700, 32767));
          2: w.in_year = YEAR_W'($urandom_range(0, 3000));
          default: w.in_year = YEAR_W'($urandom_range(1890, 2110));
        endcase
        w.in_month = MONTH_W'($urandom_range(1, 12));
        len = month_days(int'(w.in_month), int'(w.in_year));
        w.in_day = DAY_W'(($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len));
        case (w.func)
          FN_MONTHS: begin
            if (big_left > 0 && $urandom_range(0, 19) == 0) begin
              big_left--;
              w.count = CNT_W'($urandom_range(0, 32767));
            end else begin
              w.count = CNT_W'($urandom_range(0, 400));
            end
          end
          default: begin
            w.count = CNT_W'($urandom_range(0, 1) ? $urandom_range(0, 32767)
                                                   : $urandom_range(0, 400));
          end
        endcase
      end
      send_date(w, predict_date(w));
    end

    @(negedge clk);
    req.valid = 1'b0;
    while (expected_dates.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words: %0d add days, %0d add months, %0d add years, %0d unused op",
             n_func[0] + n_func[1] + n_func[2] + n_func[3],
             n_func[0], n_func[1], n_func[2], n_func[3]);
    $display("results: %0d ok, %0d invalid date, %0d year overflow, %0d mismatches",
             n_ok, n_invalid, n_overflow, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("timeout with %0d results outstanding", expected_dates.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* gregorian_date_adder.f */
rtl/gda_pkg.sv
rtl/gda_if.sv
rtl/gda_urom.sv
rtl/gda_seq.sv
rtl/gda_dp.sv
rtl/gregorian_date_adder.sv
verif/gregorian_date_adder_tb.sv
